>>> rtl/core/hbp_pkg.sv
package hbp_pkg;

    localparam int NUM_SYMBOLS       = 256;
    localparam int SYM_W             = 8;
    localparam int LEN_IN_W          = 6;
    localparam int CODE_IN_W         = 32;
    localparam int BYTE_W            = 8;
    localparam int PEND_W            = 7;
    localparam int PCNT_W            = 3;
    localparam int DEF_MAX_CODE_BITS = 32;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_stage_ctl;

    function automatic logic [BYTE_W-1:0] low_mask(input logic [PCNT_W-1:0] count);
        logic [BYTE_W-1:0] mask;
        case (count)
            3'd0:    mask = 8'd0;
            3'd1:    mask = 8'd1;
            3'd2:    mask = 8'd3;
            3'd3:    mask = 8'd7;
            3'd4:    mask = 8'd15;
            3'd5:    mask = 8'd31;
            3'd6:    mask = 8'd63;
            3'd7:    mask = 8'd127;
            default: mask = 8'd255;
        endcase
        return mask;
    endfunction

endpackage

>>> rtl/core/hbp_lookup.sv
module hbp_lookup
    import hbp_pkg::*;
#(
    parameter int CODE_W = DEF_MAX_CODE_BITS,
    parameter int LEN_W  = $clog2(DEF_MAX_CODE_BITS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_cmd                 i_cmd,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [LEN_IN_W-1:0]  i_code_length,
    input  logic [CODE_IN_W-1:0] i_code_value,
    input  logic                 i_advance,
    output t_stage_ctl           o_ctl,
    output logic [LEN_W-1:0]     o_len,
    output logic [CODE_W-1:0]    o_code
);

    localparam int ENT_W = LEN_W + CODE_W;

    logic [ENT_W-1:0]       r_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_vld;
    logic                   r_valid;
    logic                   n_valid;
    t_cmd                   r_cmd;
    logic [ENT_W-1:0]       r_rd_data;
    logic                   r_rd_hit;

    logic [LEN_IN_W-1:0]    len_sat;
    logic [CODE_W-1:0]      code_masked;
    logic                   wr_en;

    assign wr_en   = i_accept && (i_cmd == CMD_LOAD);
    assign len_sat = (i_code_length > LEN_IN_W'(CODE_W)) ? LEN_IN_W'(CODE_W) : i_code_length;

    always_comb begin
        for (int i = 0; i < CODE_W; i++) begin
            code_masked[i] = i_code_value[i] && (LEN_IN_W'(i) < len_sat);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_symbol] <= {len_sat[LEN_W-1:0], code_masked};
        end
        if (i_accept) begin
            r_rd_data <= r_mem[i_symbol];
            r_rd_hit  <= r_vld[i_symbol];
            r_cmd     <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (wr_en) begin
                r_vld[i_symbol] <= 1'b1;
            end
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.cmd   = r_cmd;
    assign o_len       = r_rd_hit ? r_rd_data[ENT_W-1:CODE_W] : '0;
    assign o_code      = r_rd_data[CODE_W-1:0];

endmodule

>>> rtl/core/hbp_packer.sv
module hbp_packer
    import hbp_pkg::*;
#(
    parameter int CODE_W = DEF_MAX_CODE_BITS,
    parameter int LEN_W  = $clog2(DEF_MAX_CODE_BITS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stage_ctl        i_ctl,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_m_tready,
    output logic              o_advance,
    output logic              o_m_tvalid,
    output logic [BYTE_W-1:0] o_m_tdata,
    output logic              o_m_tlast
);

    localparam int ACC_W     = CODE_W + PEND_W;
    localparam int MAX_BYTES = ACC_W / BYTE_W;
    localparam int BUF_W     = MAX_BYTES * BYTE_W;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);
    localparam int TOT_W     = $clog2(ACC_W + 1);

    logic [BUF_W-1:0]  r_buf,  n_buf;
    logic [NB_W-1:0]   r_bcnt, n_bcnt;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [PCNT_W-1:0] r_pcnt, n_pcnt;

    logic [BYTE_W-1:0] mask_cur;
    logic [BYTE_W-1:0] mask_new;
    logic [PEND_W-1:0] pend_m;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  rest;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  shamt;
    logic [PEND_W-1:0] new_pend;
    logic [NB_W-1:0]   nb;
    logic [BUF_W-1:0]  buf_data;
    logic              buf_free;
    logic              take;
    logic              load;

    assign mask_cur = low_mask(r_pcnt);
    assign pend_m   = r_pend & mask_cur[PEND_W-1:0];
    assign acc      = ACC_W'(pend_m) | (ACC_W'(i_code) << r_pcnt);
    assign total    = TOT_W'(r_pcnt) + TOT_W'(i_len);
    assign shamt    = {total[TOT_W-1:3], 3'b000};
    assign rest     = acc >> shamt;
    assign mask_new = low_mask(total[2:0]);
    assign new_pend = rest[PEND_W-1:0] & mask_new[PEND_W-1:0];

    always_comb begin
        nb       = '0;
        buf_data = acc[BUF_W-1:0];
        case (i_ctl.cmd)
            CMD_ENCODE: begin
                nb = NB_W'(total >> 3);
            end
            CMD_FLUSH: begin
                nb       = (r_pcnt != '0) ? NB_W'(1) : '0;
                buf_data = BUF_W'(pend_m);
            end
            default: begin
                nb = '0;
            end
        endcase
    end

    assign take      = (r_bcnt != '0) && i_m_tready;
    assign buf_free  = (r_bcnt == '0) || ((r_bcnt == NB_W'(1)) && i_m_tready);
    assign o_advance = i_ctl.valid && ((nb == '0) || buf_free);
    assign load      = o_advance && (nb != '0);

    always_comb begin
        n_bcnt = r_bcnt;
        n_buf  = r_buf;
        if (load) begin
            n_bcnt = nb;
            n_buf  = buf_data;
        end else if (take) begin
            n_bcnt = r_bcnt - NB_W'(1);
            n_buf  = r_buf >> BYTE_W;
        end
    end

    always_comb begin
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        if (o_advance) begin
            case (i_ctl.cmd)
                CMD_ENCODE: begin
                    n_pend = new_pend;
                    n_pcnt = total[2:0];
                end
                CMD_FLUSH: begin
                    n_pend = '0;
                    n_pcnt = '0;
                end
                default: begin
                    n_pend = r_pend;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
            r_pend <= '0;
            r_pcnt <= '0;
        end else begin
            r_bcnt <= n_bcnt;
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
        end
    end

    assign o_m_tvalid = (r_bcnt != '0);
    assign o_m_tdata  = r_buf[BYTE_W-1:0];
    assign o_m_tlast  = (r_bcnt == NB_W'(1));

`ifndef ASSERT_OFF
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && (i_ctl.cmd == CMD_FLUSH)) |=> (r_pcnt == '0))
        else $error("pending bits left after flush");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_m_tvalid && (r_bcnt == $past(nb))))
        else $error("byte buffer count does not match loaded transaction");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (r_bcnt == $past(r_bcnt)))
        else $error("byte buffer changed while output stalled");
`endif

endmodule

>>> rtl/core/huffman_table_bit_packer.sv
// Table-driven Huffman encoder, LSB-first bit packer.
// Input stream: s_axis_tuser carries the command (load, encode, flush), s_axis_tdata
// the symbol, code length and code bits. A load writes one table entry; an encode
// appends the symbol's code to the bit stream; a flush emits the partial byte.
// Output stream: one packed byte per transaction, tlast on the final byte of the
// input transaction that caused it. Loads, zero-length symbols and empty flushes
// produce no output.
// Path: the first byte of an encode passes the table read register, then the output
// byte buffer, and it waits in the lookup register while that buffer is not free.
// Draining: each input transaction emits N bytes (0..4) through the one-byte output
// port from the byte buffer; the next one that emits bytes loads as the last is taken.
// Reset: the whole table reads as length zero at once (per-entry valid flags, no
// clearing pass), pending bits are dropped, both sides come up empty.
// Stall: while m_axis_tready is low the byte buffer holds; transactions that emit
// no bytes still pass, the first one that emits bytes waits in the lookup register,
// then s_axis_tready drops.
module huffman_table_bit_packer
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // symbol[7:0], code_length[13:8], code_value[45:14]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
    output logic        m_axis_tlast
);

    localparam int CODE_W = (MAX_CODE_BITS < CODE_IN_W) ? MAX_CODE_BITS : CODE_IN_W;
    localparam int LEN_W  = $clog2(CODE_W + 1);

    t_stage_ctl          ctl;
    logic [LEN_W-1:0]    len;
    logic [CODE_W-1:0]   code;
    logic                advance;
    logic                accept;

    assign s_axis_tready = !ctl.valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    hbp_lookup #(
        .CODE_W (CODE_W),
        .LEN_W  (LEN_W)
    ) u_lookup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (t_cmd'(s_axis_tuser)),
        .i_symbol      (s_axis_tdata[7:0]),
        .i_code_length (s_axis_tdata[13:8]),
        .i_code_value  (s_axis_tdata[45:14]),
        .i_advance     (advance),
        .o_ctl         (ctl),
        .o_len         (len),
        .o_code        (code)
    );

    hbp_packer #(
        .CODE_W (CODE_W),
        .LEN_W  (LEN_W)
    ) u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_len      (len),
        .i_code     (code),
        .i_m_tready (m_axis_tready),
        .o_advance  (advance),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule
